[sv/plde_pkg.sv]
// ----------------------------------------------------------------------------
// plde_pkg
// Shared constants, codes and helpers of the pairwise LD r-squared engine.
// ----------------------------------------------------------------------------
package plde_pkg;

   localparam int PLDE_MAX_LOCI    = 64;
   localparam int PLDE_MAX_SAMPLES = 4096;

   localparam int ACTION_W    = 2;
   localparam int DOSAGE_W    = 10;
   localparam int LOCUS_W     = 6;
   localparam int R2_W        = 17;
   localparam int NUM_LOCI_W  = 7;
   localparam int VAR_FLOOR_W = 16;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;
   // wide enough for any locus count up to 256
   localparam int LOC_W       = 9;

   typedef logic [ACTION_W-1:0]    action_type;
   typedef logic [DOSAGE_W-1:0]    dosage_type;
   typedef logic [LOCUS_W-1:0]     locus_type;
   typedef logic [R2_W-1:0]        r2_type;
   typedef logic [CSR_IDX_W-1:0]   csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [NUM_LOCI_W-1:0]  num_loci_type;
   typedef logic [VAR_FLOOR_W-1:0] var_floor_type;
   typedef logic [LOC_W-1:0]       loc_type;

   localparam action_type ACT_LOAD  = 2'd0;
   localparam action_type ACT_EMIT  = 2'd1;
   localparam action_type ACT_CLEAR = 2'd2;

   localparam csr_idx_type CSR_NUM_LOCI  = 4'd0;
   localparam csr_idx_type CSR_VAR_FLOOR = 4'd1;

   localparam num_loci_type  NUM_LOCI_RST  = 7'd64;
   localparam var_floor_type VAR_FLOOR_RST = 16'd429;
   localparam dosage_type    DOSAGE_MAX    = 10'd512;
   localparam r2_type        R2_ONE        = 17'd65536;

   // offset of pair (k, j), k <= j, in the packed upper triangle
   function automatic logic [15:0] plde_tri(logic [7:0] k, logic [7:0] j);
      logic [16:0] jj;
      jj = 17'(j) * (17'(j) + 17'd1);
      return 16'(jj >> 1) + 16'(k);
   endfunction

endpackage

[sv/plde_if.sv]
// ----------------------------------------------------------------------------
// plde_if
// Valid/ready channels of the pairwise LD r-squared engine.
// ----------------------------------------------------------------------------
interface plde_req_if import plde_pkg::*; ();
   logic       valid;
   logic       ready;
   action_type action;
   dosage_type dosage;
   modport source (output valid, output action, output dosage, input ready);
   modport sink   (input valid, input action, input dosage, output ready);
endinterface

interface plde_rsp_if import plde_pkg::*; ();
   logic      valid;
   logic      ready;
   locus_type locus_first;
   locus_type locus_second;
   r2_type    r_squared;
   logic      last_pair;
   modport source (output valid, output locus_first, output locus_second,
                   output r_squared, output last_pair, input ready);
   modport sink   (input valid, input locus_first, input locus_second,
                   input r_squared, input last_pair, output ready);
endinterface

interface plde_csr_if import plde_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

[sv/plde_mult.sv]
// ----------------------------------------------------------------------------
// plde_mult
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module plde_mult import plde_pkg::*; #(
   parameter int W = 44
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   output logic           done,
   output logic [2*W-1:0] prod
);
   localparam int CW = $clog2(W + 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [2*W-1:0] acc_ff, acc_in;
   logic [2*W-1:0] mcd_ff, mcd_in;
   logic [W-1:0]   mpl_ff, mpl_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      mcd_in  = mcd_ff;
      mpl_in  = mpl_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         mcd_in  = (2*W)'(a);
         mpl_in  = b;
      end else if (busy_ff) begin
         if (mpl_ff[0]) begin
            acc_in = acc_ff + mcd_ff;
         end
         mcd_in = mcd_ff << 1;
         mpl_in = mpl_ff >> 1;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      mcd_ff <= mcd_in;
      mpl_ff <= mpl_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

[sv/plde_div.sv]
// ----------------------------------------------------------------------------
// plde_div
// Restoring fraction divider: 17 quotient bits of num/den (num < den),
// one bit per cycle, rounded half up to Q1.16.
// ----------------------------------------------------------------------------
module plde_div import plde_pkg::*; #(
   parameter int W = 44
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [2*W-1:0] num,
   input  logic [2*W-1:0] den,
   output logic           done,
   output r2_type         quot
);
   localparam int QCW = $clog2(R2_W + 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [QCW-1:0] cnt_ff, cnt_in;
   logic [2*W-1:0] rem_ff, rem_in;
   logic [2*W-1:0] den_ff, den_in;
   r2_type         q_ff, q_in;
   logic [2*W:0]   rem_sh;
   logic           ge;
   logic [R2_W:0]  q_rnd;

   assign rem_sh = {rem_ff, 1'b0};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num;
         den_in  = den;
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in = ge ? (2*W)'(rem_sh - {1'b0, den_ff}) : (2*W)'(rem_sh);
         q_in   = {q_ff[R2_W-2:0], ge};
         cnt_in = cnt_ff + QCW'(1);
         if (cnt_ff == QCW'(R2_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   // round half up: drop the guard bit
   assign q_rnd = ({1'b0, q_ff} + (R2_W+1)'(1)) >> 1;
   assign quot  = R2_W'(q_rnd);
   assign done  = done_ff;

endmodule

[sv/pairwise_ld_r2_engine.sv]
// ----------------------------------------------------------------------------
// pairwise_ld_r2_engine
// Accumulates locus and cross-product sums of a dosage matrix in memories and
// returns r-squared for every locus pair on request.
// ----------------------------------------------------------------------------
// Load: a dosage at column p takes one read-modify-write of the cross-sum
//   memory per column of the row up to and including p (S_LRD, S_LWR).
// Emit: ten products on the shift-add multiplier (MW bits, one bit a cycle),
//   then a 17-step divider unless the result is zero or one.
// Clear and reset: a sweep of MAX_LOCI*(MAX_LOCI+1)/2 slots zeroes the sum
//   memories; no item is taken meanwhile. One item is worked on at a time.
module pairwise_ld_r2_engine import plde_pkg::*; #(
   parameter int MAX_LOCI    = PLDE_MAX_LOCI,
   parameter int MAX_SAMPLES = PLDE_MAX_SAMPLES
) (
   input  logic        clock,
   input  logic        reset,
   plde_req_if.sink    req_ch,
   plde_rsp_if.source  rsp_ch,
   plde_csr_if.sink    csr_ch
);
   localparam int PAIR  = MAX_LOCI * (MAX_LOCI + 1) / 2;
   localparam int PW    = $clog2(MAX_LOCI);
   localparam int XA_W  = $clog2(PAIR);
   localparam int N_W   = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = $clog2(512 * MAX_SAMPLES + 1);
   localparam int XS_W  = $clog2(64'd262144 * MAX_SAMPLES + 1);
   localparam int MW_A  = N_W + XS_W;
   localparam int MW_B  = (2 * SUM_W > MW_A) ? 2 * SUM_W : MW_A;
   localparam int MW    = (16 + 2 * N_W > MW_B) ? 16 + 2 * N_W : MW_B;

   localparam logic [XA_W-1:0] LOCI_A    = XA_W'(MAX_LOCI);
   localparam logic [XA_W-1:0] PAIR_LAST = XA_W'(PAIR - 1);
   localparam logic [N_W-1:0]  N_FULL    = N_W'(MAX_SAMPLES);
   localparam loc_type         LOC_MAX   = LOC_W'(MAX_LOCI);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_LRD  = 4'd2;
   localparam logic [3:0] S_LWR  = 4'd3;
   localparam logic [3:0] S_ER0  = 4'd4;
   localparam logic [3:0] S_ER1  = 4'd5;
   localparam logic [3:0] S_ER2  = 4'd6;
   localparam logic [3:0] S_ER3  = 4'd7;
   localparam logic [3:0] S_MGO  = 4'd8;
   localparam logic [3:0] S_MWT  = 4'd9;
   localparam logic [3:0] S_DEC  = 4'd10;
   localparam logic [3:0] S_DWT  = 4'd11;
   localparam logic [3:0] S_OUT  = 4'd12;

   // product sequence of one emission
   localparam logic [3:0] M_NXII = 4'd0;
   localparam logic [3:0] M_SISI = 4'd1;
   localparam logic [3:0] M_NXJJ = 4'd2;
   localparam logic [3:0] M_SJSJ = 4'd3;
   localparam logic [3:0] M_NN   = 4'd4;
   localparam logic [3:0] M_LIM  = 4'd5;
   localparam logic [3:0] M_NXIJ = 4'd6;
   localparam logic [3:0] M_SISJ = 4'd7;
   localparam logic [3:0] M_NUM  = 4'd8;
   localparam logic [3:0] M_DEN  = 4'd9;

   // memories
   logic [DOSAGE_W-1:0] rb_mem  [MAX_LOCI];
   logic [SUM_W-1:0]    col_mem [MAX_LOCI];
   logic [XS_W-1:0]     xs_mem  [PAIR];

   logic [DOSAGE_W-1:0] rb_rd_ff;
   logic [SUM_W-1:0]    col_rd_ff;
   logic [XS_W-1:0]     xs_rd_ff;

   logic                rb_we, col_we, xs_we;
   logic [PW-1:0]       rb_addr, col_waddr, col_raddr;
   logic [XA_W-1:0]     xs_waddr, xs_raddr;
   logic [DOSAGE_W-1:0] rb_wdata;
   logic [SUM_W-1:0]    col_wdata;
   logic [XS_W-1:0]     xs_wdata;

   // control and working registers
   logic [3:0]          state_ff, state_in;
   logic [XA_W-1:0]     clr_cnt_ff, clr_cnt_in;
   num_loci_type        num_loci_ff, num_loci_in;
   var_floor_type       var_floor_ff, var_floor_in;
   logic [N_W-1:0]      rows_ff, rows_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic [PW-1:0]       ei_ff, ei_in;
   logic [PW-1:0]       ej_ff, ej_in;
   logic [PW-1:0]       k_ff, k_in;
   dosage_type          x_ff, x_in;
   logic [PW-1:0]       ea_ff, ea_in;
   logic [PW-1:0]       eb_ff, eb_in;
   logic                last_ff, last_in;
   logic [3:0]          mstep_ff, mstep_in;
   logic [SUM_W-1:0]    si_ff, si_in;
   logic [SUM_W-1:0]    sj_ff, sj_in;
   logic [XS_W-1:0]     xii_ff, xii_in;
   logic [XS_W-1:0]     xjj_ff, xjj_in;
   logic [XS_W-1:0]     xij_ff, xij_in;
   logic [2*MW-1:0]     p0_ff, p0_in;
   logic [MW-1:0]       di_ff, di_in;
   logic [MW-1:0]       dj_ff, dj_in;
   logic [MW-1:0]       cmag_ff, cmag_in;
   logic [2*MW-1:0]     lim_ff, lim_in;
   logic [2*MW-1:0]     num_ff, num_in;
   logic [2*MW-1:0]     den_ff, den_in;
   r2_type              res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   locus_type           rsp_first_ff, rsp_first_in;
   locus_type           rsp_second_ff, rsp_second_in;
   r2_type              rsp_r2_ff, rsp_r2_in;
   logic                rsp_last_ff, rsp_last_in;

   // arithmetic units
   logic                mul_start, mul_done;
   logic [MW-1:0]       mul_a, mul_b;
   logic [2*MW-1:0]     mul_prod;
   logic                div_start, div_done;
   r2_type              div_quot;

   plde_mult #(.W(MW)) u_mult (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   plde_div #(.W(MW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // effective loci count, clamped to 2..MAX_LOCI
   loc_type loci;
   loc_type nl_ext;
   assign nl_ext = LOC_W'(num_loci_ff);
   assign loci   = (nl_ext < LOC_W'(2)) ? LOC_W'(2) :
                   (nl_ext > LOC_MAX) ? LOC_MAX : nl_ext;

   // pair selection for an emit request
   loc_type       ei_x, ej_x, pa_x, pb_x;
   logic          pair_bad, pair_last;
   logic [PW-1:0] pa, pb;
   assign ei_x      = LOC_W'(ei_ff);
   assign ej_x      = LOC_W'(ej_ff);
   assign pair_bad  = (ej_x >= loci) || (ei_x >= ej_x);
   assign pa        = pair_bad ? PW'(0) : ei_ff;
   assign pb        = pair_bad ? PW'(1) : ej_ff;
   assign pa_x      = LOC_W'(pa);
   assign pb_x      = LOC_W'(pb);
   assign pair_last = (pb_x == loci - LOC_W'(1)) && (pa_x == loci - LOC_W'(2));

   // load datapath
   logic [DOSAGE_W-1:0]   rb_val;
   logic [2*DOSAGE_W-1:0] xprod;
   logic [XA_W-1:0]       tri_kp;
   assign rb_val = (k_ff == pos_ff) ? x_ff : rb_rd_ff;
   assign xprod  = rb_val * x_ff;
   assign tri_kp = XA_W'(plde_tri(8'(k_ff), 8'(pos_ff)));

   // emission decision
   logic [2*MW-1:0] di_sh, dj_sh;
   logic            r2_zero;
   assign di_sh   = (2*MW)'({di_ff, 16'b0});
   assign dj_sh   = (2*MW)'({dj_ff, 16'b0});
   assign r2_zero = (rows_ff < N_W'(2)) || (di_sh < lim_ff) || (dj_sh < lim_ff) ||
                    (di_ff == '0) || (dj_ff == '0);

   // read addresses
   always_comb begin
      col_raddr = pos_ff;
      xs_raddr  = tri_kp;
      unique case (state_ff)
         S_ER0: begin
            col_raddr = ea_ff;
            xs_raddr  = XA_W'(plde_tri(8'(ea_ff), 8'(ea_ff)));
         end
         S_ER1: begin
            col_raddr = eb_ff;
            xs_raddr  = XA_W'(plde_tri(8'(eb_ff), 8'(eb_ff)));
         end
         S_ER2: begin
            xs_raddr  = XA_W'(plde_tri(8'(ea_ff), 8'(eb_ff)));
         end
         default: begin
         end
      endcase
   end

   // multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (mstep_ff)
         M_NXII: begin mul_a = MW'(rows_ff);      mul_b = MW'(xii_ff);         end
         M_SISI: begin mul_a = MW'(si_ff);        mul_b = MW'(si_ff);          end
         M_NXJJ: begin mul_a = MW'(rows_ff);      mul_b = MW'(xjj_ff);         end
         M_SJSJ: begin mul_a = MW'(sj_ff);        mul_b = MW'(sj_ff);          end
         M_NN:   begin
            mul_a = MW'(rows_ff);
            mul_b = MW'(rows_ff - N_W'(1));
         end
         M_LIM:  begin mul_a = MW'(var_floor_ff); mul_b = p0_ff[MW-1:0];       end
         M_NXIJ: begin mul_a = MW'(rows_ff);      mul_b = MW'(xij_ff);         end
         M_SISJ: begin mul_a = MW'(si_ff);        mul_b = MW'(sj_ff);          end
         M_NUM:  begin mul_a = cmag_ff;           mul_b = cmag_ff;             end
         M_DEN:  begin mul_a = di_ff;             mul_b = dj_ff;               end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      num_loci_in   = num_loci_ff;
      var_floor_in  = var_floor_ff;
      rows_in       = rows_ff;
      pos_in        = pos_ff;
      ei_in         = ei_ff;
      ej_in         = ej_ff;
      k_in          = k_ff;
      x_in          = x_ff;
      ea_in         = ea_ff;
      eb_in         = eb_ff;
      last_in       = last_ff;
      mstep_in      = mstep_ff;
      si_in         = si_ff;
      sj_in         = sj_ff;
      xii_in        = xii_ff;
      xjj_in        = xjj_ff;
      xij_in        = xij_ff;
      p0_in         = p0_ff;
      di_in         = di_ff;
      dj_in         = dj_ff;
      cmag_in       = cmag_ff;
      lim_in        = lim_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_r2_in     = rsp_r2_ff;
      rsp_last_in   = rsp_last_ff;
      mul_start     = 1'b0;
      div_start     = 1'b0;
      rb_we         = 1'b0;
      col_we        = 1'b0;
      xs_we         = 1'b0;
      rb_addr       = pos_ff;
      rb_wdata      = x_ff;
      col_waddr     = pos_ff;
      col_wdata     = col_rd_ff + SUM_W'(x_ff);
      xs_waddr      = tri_kp;
      xs_wdata      = xs_rd_ff + XS_W'(xprod);

      if (rsp_ch.valid && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_ch.valid) begin
         if (csr_ch.index == CSR_NUM_LOCI) begin
            num_loci_in = NUM_LOCI_W'(csr_ch.wdata);
         end else if (csr_ch.index == CSR_VAR_FLOOR) begin
            var_floor_in = csr_ch.wdata;
         end
      end

      unique case (state_ff)
         S_CLR: begin
            xs_we    = 1'b1;
            xs_waddr = clr_cnt_ff;
            xs_wdata = '0;
            if (clr_cnt_ff < LOCI_A) begin
               col_we    = 1'b1;
               col_waddr = clr_cnt_ff[PW-1:0];
               col_wdata = '0;
            end
            if (clr_cnt_ff == PAIR_LAST) begin
               state_in = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + XA_W'(1);
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               unique case (req_ch.action)
                  ACT_LOAD: begin
                     // drop loads once the sample store is full
                     if (rows_ff != N_FULL) begin
                        x_in     = (req_ch.dosage > DOSAGE_MAX) ? DOSAGE_MAX : req_ch.dosage;
                        k_in     = '0;
                        state_in = S_LRD;
                     end
                  end
                  ACT_EMIT: begin
                     ea_in   = pa;
                     eb_in   = pb;
                     last_in = pair_last;
                     if (pair_last) begin
                        ei_in = PW'(0);
                        ej_in = PW'(1);
                     end else if (pb_x + LOC_W'(1) < loci) begin
                        ei_in = pa;
                        ej_in = pb + PW'(1);
                     end else begin
                        ei_in = pa + PW'(1);
                        ej_in = pa + PW'(2);
                     end
                     state_in = S_ER0;
                  end
                  ACT_CLEAR: begin
                     rows_in    = '0;
                     pos_in     = '0;
                     ei_in      = PW'(0);
                     ej_in      = PW'(1);
                     clr_cnt_in = '0;
                     state_in   = S_CLR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LRD: begin
            state_in = S_LWR;
         end
         S_LWR: begin
            xs_we = 1'b1;
            if (k_ff == pos_ff) begin
               rb_we  = 1'b1;
               col_we = 1'b1;
               if (LOC_W'(pos_ff) + LOC_W'(1) >= loci) begin
                  pos_in  = '0;
                  rows_in = rows_ff + N_W'(1);
               end else begin
                  pos_in = pos_ff + PW'(1);
               end
               state_in = S_IDLE;
            end else begin
               k_in     = k_ff + PW'(1);
               state_in = S_LRD;
            end
         end
         S_ER0: begin
            state_in = S_ER1;
         end
         S_ER1: begin
            si_in    = col_rd_ff;
            xii_in   = xs_rd_ff;
            state_in = S_ER2;
         end
         S_ER2: begin
            sj_in    = col_rd_ff;
            xjj_in   = xs_rd_ff;
            state_in = S_ER3;
         end
         S_ER3: begin
            xij_in   = xs_rd_ff;
            mstep_in = M_NXII;
            state_in = S_MGO;
         end
         S_MGO: begin
            mul_start = 1'b1;
            state_in  = S_MWT;
         end
         S_MWT: begin
            if (mul_done) begin
               unique case (mstep_ff)
                  M_NXII, M_NXJJ, M_NN, M_NXIJ: p0_in = mul_prod;
                  M_SISI: di_in = (p0_ff >= mul_prod) ? MW'(p0_ff - mul_prod) : '0;
                  M_SJSJ: dj_in = (p0_ff >= mul_prod) ? MW'(p0_ff - mul_prod) : '0;
                  M_LIM:  lim_in = mul_prod;
                  M_SISJ: cmag_in = (p0_ff >= mul_prod) ? MW'(p0_ff - mul_prod)
                                                        : MW'(mul_prod - p0_ff);
                  M_NUM:  num_in = mul_prod;
                  M_DEN:  den_in = mul_prod;
                  default: begin
                  end
               endcase
               if (mstep_ff == M_DEN) begin
                  state_in = S_DEC;
               end else begin
                  mstep_in = mstep_ff + 4'd1;
                  state_in = S_MGO;
               end
            end
         end
         S_DEC: begin
            priority if (r2_zero) begin
               res_in   = '0;
               state_in = S_OUT;
            end else if (num_ff >= den_ff) begin
               res_in   = R2_ONE;
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = S_DWT;
            end
         end
         S_DWT: begin
            if (div_done) begin
               res_in   = div_quot;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = LOCUS_W'(ea_ff);
               rsp_second_in = LOCUS_W'(eb_ff);
               rsp_r2_in     = res_ff;
               rsp_last_in   = last_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_cnt_ff   <= '0;
         num_loci_ff  <= NUM_LOCI_RST;
         var_floor_ff <= VAR_FLOOR_RST;
         rows_ff      <= '0;
         pos_ff       <= '0;
         ei_ff        <= PW'(0);
         ej_ff        <= PW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         num_loci_ff  <= num_loci_in;
         var_floor_ff <= var_floor_in;
         rows_ff      <= rows_in;
         pos_ff       <= pos_in;
         ei_ff        <= ei_in;
         ej_ff        <= ej_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff          <= k_in;
      x_ff          <= x_in;
      ea_ff         <= ea_in;
      eb_ff         <= eb_in;
      last_ff       <= last_in;
      mstep_ff      <= mstep_in;
      si_ff         <= si_in;
      sj_ff         <= sj_in;
      xii_ff        <= xii_in;
      xjj_ff        <= xjj_in;
      xij_ff        <= xij_in;
      p0_ff         <= p0_in;
      di_ff         <= di_in;
      dj_ff         <= dj_in;
      cmag_ff       <= cmag_in;
      lim_ff        <= lim_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      res_ff        <= res_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_r2_ff     <= rsp_r2_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (rb_we) begin
         rb_mem[rb_addr] <= rb_wdata;
      end
      rb_rd_ff <= rb_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[col_waddr] <= col_wdata;
      end
      col_rd_ff <= col_mem[col_raddr];
   end

   always_ff @(posedge clock) begin
      if (xs_we) begin
         xs_mem[xs_waddr] <= xs_wdata;
      end
      xs_rd_ff <= xs_mem[xs_raddr];
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.locus_first  = rsp_first_ff;
   assign rsp_ch.locus_second = rsp_second_ff;
   assign rsp_ch.r_squared    = rsp_r2_ff;
   assign rsp_ch.last_pair    = rsp_last_ff;

endmodule

[tb/sv/tb_pairwise_ld_r2_engine.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pairwise_ld_r2_engine
// Self-checking bench: drives dosage loads, pair emits, clears and unknown
// actions through the request channel, models the locus and cross-product
// sums exactly, and checks every r-squared result field by field.
// ----------------------------------------------------------------------------
module tb_pairwise_ld_r2_engine;
   import plde_pkg::*;

   localparam int  PAIR_SLOTS   = PLDE_MAX_LOCI * (PLDE_MAX_LOCI + 1) / 2;
   localparam int  SETTLE_CYC   = 2300;
   localparam int  WATCHDOG_CYC = 20000;
   localparam int  LONG_HOLD    = 3000;
   localparam int  PHASE_ITEMS  = 230;
   localparam action_type ACT_NONE = 2'd3;
   localparam csr_idx_type CSR_SPARE = 4'd15;

   typedef struct packed {
      action_type act;
      dosage_type dos;
   } req_item_type;

   typedef struct packed {
      locus_type first;
      locus_type second;
      r2_type    r2;
      logic      last;
   } pair_result_type;

   logic clock;
   logic reset;

   plde_req_if req_if ();
   plde_rsp_if rsp_if ();
   plde_csr_if csr_if ();

   pairwise_ld_r2_engine DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // model state
   logic [9:0]      row_buf [PLDE_MAX_LOCI];
   longint unsigned locus_sum [PLDE_MAX_LOCI];
   longint unsigned cross_sum [PAIR_SLOTS];
   int              rows_done;
   int              col_pos;
   int              next_first;
   int              next_second;
   num_loci_type    cfg_loci;
   var_floor_type   cfg_floor;

   req_item_type    pending_q [$];
   pair_result_type pair_q [$];

   int  src_idle_pct;
   int  rsp_stall_pct;
   int  hold_kick;
   int  hold_ack;
   int  hold_left;
   bit  req_fire;
   int  mismatches;
   int  n_load, n_emit, n_clear, n_none, n_csr, n_rsp, n_nonzero, n_last;
   int  quiet_cycles;
   int  gen_loci;

   function automatic int loci_used();
      int l;
      l = cfg_loci;
      if (l < 2) l = 2;
      if (l > PLDE_MAX_LOCI) l = PLDE_MAX_LOCI;
      return l;
   endfunction

   function automatic int slot(int k, int j);
      return j * (j + 1) / 2 + k;
   endfunction

   function automatic logic [127:0] centered(logic [127:0] n, logic [127:0] s1,
                                            logic [127:0] s2, logic [127:0] c);
      logic [127:0] a, b;
      a = n * c;
      b = s1 * s2;
      return (a >= b) ? a - b : 128'd0;
   endfunction

   function automatic r2_type pair_r2(int i, int j);
      logic [127:0] n, di, dj, lim, a, b, cm, num, den, q;
      n = rows_done;
      if (rows_done < 2) return '0;
      di  = centered(n, locus_sum[i], locus_sum[i], cross_sum[slot(i, i)]);
      dj  = centered(n, locus_sum[j], locus_sum[j], cross_sum[slot(j, j)]);
      lim = 128'(cfg_floor) * n * (n - 1);
      if ((di << 16) < lim || (dj << 16) < lim) return '0;
      if (di == 0 || dj == 0) return '0;
      a   = n * cross_sum[slot(i, j)];
      b   = 128'(locus_sum[i]) * locus_sum[j];
      cm  = (a >= b) ? a - b : b - a;
      num = cm * cm;
      den = di * dj;
      if (num >= den) return R2_ONE;
      q = ((num << 17) / den + 1) >> 1;
      if (q > R2_ONE) q = R2_ONE;
      return r2_type'(q);
   endfunction

   function automatic void model_reset();
      for (int k = 0; k < PLDE_MAX_LOCI; k++) begin
         row_buf[k]   = '0;
         locus_sum[k] = 0;
      end
      for (int k = 0; k < PAIR_SLOTS; k++) cross_sum[k] = 0;
      rows_done   = 0;
      col_pos     = 0;
      next_first  = 0;
      next_second = 1;
   endfunction

   function automatic void model_item(req_item_type it);
      int l, pos, i, j;
      logic [9:0] x;
      pair_result_type res;
      l = loci_used();
      case (it.act)
         ACT_LOAD: begin
            n_load++;
            if (rows_done >= PLDE_MAX_SAMPLES) return;
            pos = col_pos % PLDE_MAX_LOCI;
            x = (it.dos > DOSAGE_MAX) ? DOSAGE_MAX : it.dos;
            row_buf[pos] = x;
            locus_sum[pos] += x;
            for (int k = 0; k <= pos; k++)
               cross_sum[slot(k, pos)] += longint'(row_buf[k]) * x;
            if (pos + 1 >= l) begin
               col_pos = 0;
               rows_done++;
            end else begin
               col_pos = pos + 1;
            end
         end
         ACT_CLEAR: begin
            n_clear++;
            for (int k = 0; k < PLDE_MAX_LOCI; k++) locus_sum[k] = 0;
            for (int k = 0; k < PAIR_SLOTS; k++) cross_sum[k] = 0;
            rows_done   = 0;
            col_pos     = 0;
            next_first  = 0;
            next_second = 1;
         end
         ACT_EMIT: begin
            n_emit++;
            i = next_first;
            j = next_second;
            if (j >= l || i >= j) begin
               i = 0;
               j = 1;
            end
            res.first  = locus_type'(i);
            res.second = locus_type'(j);
            res.r2     = pair_r2(i, j);
            res.last   = (j == l - 1 && i == l - 2);
            pair_q.push_back(res);
            if (res.last) begin
               i = 0;
               j = 1;
            end else if (j + 1 < l) begin
               j++;
            end else begin
               i++;
               j = i + 1;
            end
            next_first  = i;
            next_second = j;
         end
         default: n_none++;
      endcase
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever begin
         #6 clock = 1'b1;
         #6 clock = 1'b0;
      end
   end

   // request driver: present the next queued item once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid  <= 1'b0;
         req_if.action <= ACT_LOAD;
         req_if.dosage <= '0;
      end else if (!req_if.valid || req_fire) begin
         if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
            req_item_type it;
            it = pending_q.pop_front();
            req_if.valid  <= 1'b1;
            req_if.action <= it.act;
            req_if.dosage <= it.dos;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result ready: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (hold_kick != hold_ack) begin
         hold_ack  = hold_kick;
         hold_left = LONG_HOLD;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // acceptance, prediction, result checking and watchdog
   always @(posedge clock) begin
      req_fire = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_item_type it;
            it.act = req_if.action;
            it.dos = req_if.dosage;
            req_fire = 1'b1;
            model_item(it);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            pair_result_type got, exp_res;
            got.first  = rsp_if.locus_first;
            got.second = rsp_if.locus_second;
            got.r2     = rsp_if.r_squared;
            got.last   = rsp_if.last_pair;
            n_rsp++;
            if (got.r2 != 0) n_nonzero++;
            if (got.last) n_last++;
            if (pair_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected result pair (%0d,%0d) r2=%0d last=%0b",
                           got.first, got.second, got.r2, got.last);
            end else begin
               exp_res = pair_q.pop_front();
               if (got !== exp_res) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"ERROR: pair exp (%0d,%0d) r2=%0d last=%0b, ",
                               "got (%0d,%0d) r2=%0d last=%0b"},
                              exp_res.first, exp_res.second, exp_res.r2, exp_res.last,
                              got.first, got.second, got.r2, got.last);
               end
            end
         end
         if (req_fire || (rsp_if.valid && rsp_if.ready) || (csr_if.valid && csr_if.ready) ||
             (pending_q.size() == 0 && !req_if.valid && pair_q.size() == 0))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_CYC) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_CYC);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic push_item(action_type act, int dos);
      req_item_type it;
      it.act = act;
      it.dos = dosage_type'(dos);
      pending_q.push_back(it);
   endtask

   // hold until every item is taken and every result is back, then let the
   // block finish any load or clear sweep still running
   task automatic drain();
      while (pending_q.size() != 0 || req_if.valid || pair_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic csr_write(csr_idx_type idx, int data);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.wdata = csr_data_type'(data);
      do @(posedge clock); while (!csr_if.ready);
      n_csr++;
      if (idx == CSR_NUM_LOCI) cfg_loci = num_loci_type'(data);
      else if (idx == CSR_VAR_FLOOR) cfg_floor = var_floor_type'(data);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   function automatic int rand_dosage(int base);
      case ($urandom_range(3))
         0: return base;
         1: return 512 - base;
         2: return base + $urandom_range(0, 40);
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   // mostly complete rows followed by a sweep of emits; the rest is noise
   task automatic gen_random(int budget);
      int count, rows, emits, base;
      count = 0;
      while (count < budget) begin
         if ($urandom_range(99) < 70) begin
            if ($urandom_range(99) < 6) begin
               push_item(ACT_CLEAR, $urandom_range(0, 1023));
               count++;
            end
            rows = $urandom_range(2, 6);
            for (int r = 0; r < rows; r++) begin
               base = $urandom_range(0, 512);
               for (int c = 0; c < gen_loci; c++) push_item(ACT_LOAD, rand_dosage(base));
            end
            emits = gen_loci * (gen_loci - 1) / 2 + $urandom_range(0, 2);
            for (int e = 0; e < emits; e++) push_item(ACT_EMIT, $urandom_range(0, 1023));
            count += rows * gen_loci + emits;
         end else begin
            for (int k = $urandom_range(1, 4); k > 0; k--) begin
               case ($urandom_range(9))
                  0:       push_item(ACT_NONE, $urandom_range(0, 1023));
                  1, 2, 3: push_item(ACT_EMIT, $urandom_range(0, 1023));
                  default: push_item(ACT_LOAD, $urandom_range(0, 1023));
               endcase
               count++;
            end
         end
      end
   endtask

   initial begin
      int pcts [4][2];
      pcts = '{'{0, 0}, '{80, 0}, '{0, 80}, '{27, 27}};
      reset = 1'b1;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_NUM_LOCI;
      csr_if.wdata = '0;
      src_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_kick = 0;
      cfg_loci = NUM_LOCI_RST;
      cfg_floor = VAR_FLOOR_RST;
      model_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (SETTLE_CYC) @(posedge clock);

      // directed: emit with no rows, then a three-locus matrix with extremes
      push_item(ACT_EMIT, 0);
      drain();
      csr_write(CSR_NUM_LOCI, 3);
      csr_write(CSR_VAR_FLOOR, 0);
      push_item(ACT_LOAD, 0);   push_item(ACT_LOAD, 512);  push_item(ACT_LOAD, 1023);
      push_item(ACT_LOAD, 512); push_item(ACT_LOAD, 0);    push_item(ACT_LOAD, 600);
      push_item(ACT_LOAD, 256); push_item(ACT_LOAD, 256);  push_item(ACT_LOAD, 513);
      push_item(ACT_NONE, 1023);
      for (int e = 0; e < 4; e++) push_item(ACT_EMIT, 1023);
      push_item(ACT_LOAD, 341);
      push_item(ACT_EMIT, 0);
      push_item(ACT_CLEAR, 0);
      push_item(ACT_EMIT, 0);
      drain();

      // shrink the locus count mid-row and with the emit pair out of range
      csr_write(CSR_NUM_LOCI, 8);
      for (int k = 0; k < 21; k++) push_item(ACT_LOAD, $urandom_range(0, 1023));
      for (int e = 0; e < 6; e++) push_item(ACT_EMIT, 0);
      drain();
      csr_write(CSR_NUM_LOCI, 3);
      push_item(ACT_LOAD, 100);
      push_item(ACT_EMIT, 0);
      push_item(ACT_EMIT, 0);
      drain();

      // full width: raw count 127 clamps to the maximum
      csr_write(CSR_NUM_LOCI, 16'hFF80 | 127);
      csr_write(CSR_VAR_FLOOR, 65535);
      csr_write(CSR_SPARE, 16'h5A5A);
      push_item(ACT_CLEAR, 0);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < PLDE_MAX_LOCI; c++) push_item(ACT_LOAD, $urandom_range(0, 512));
      for (int e = 0; e < 12; e++) push_item(ACT_EMIT, 0);
      drain();

      // random phases, each with its own idling mix and settings
      for (int p = 0; p < 4; p++) begin
         src_idle_pct  = pcts[p][0];
         rsp_stall_pct = pcts[p][1];
         gen_loci = (p == 0) ? 2 : $urandom_range(2, 6);
         csr_write(CSR_NUM_LOCI, (gen_loci == 2) ? 0 : gen_loci);
         case (p)
            0: csr_write(CSR_VAR_FLOOR, 0);
            1: csr_write(CSR_VAR_FLOOR, VAR_FLOOR_RST);
            2: csr_write(CSR_VAR_FLOOR, 65535);
            default: csr_write(CSR_VAR_FLOOR, $urandom_range(0, 65535));
         endcase
         if (p == 1) begin
            // stall results while emits pile up at the input
            hold_kick++;
            for (int e = 0; e < 20; e++) push_item(ACT_EMIT, 0);
         end
         gen_random(PHASE_ITEMS);
         drain();
      end

      $display("Covered %0d loads, %0d emits, %0d clears, %0d unknown actions, %0d csr writes",
               n_load, n_emit, n_clear, n_none, n_csr);
      $display("Checked %0d results: %0d nonzero r2, %0d last-pair flags, %0d mismatches",
               n_rsp, n_nonzero, n_last, mismatches);
      if (mismatches == 0 && pair_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
